// ===== hw/rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg: shared definitions for the indexed list store
// Widths, operation and status codes, controller states and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ils_pkg;

    // Number of entries the store can hold. The payload field widths below
    // are fixed by the interface and sized for this capacity.
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int POS_W    = 8;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 2;
    localparam int FPOS_W   = 6;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_SET    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_GET    = 3'd4,
        OP_FIND   = 3'd5,
        OP_CLEAR  = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_WALK,
        CS_FINISH
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch an accepted request word
        logic rd_en;   // read the entry under the walk pointer
        logic walk;    // walk in progress: move, capture and compare
        logic finish;  // final write, count update and result load
    } ils_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_walk; // the request on the input needs a pass over entries
        logic more;      // reads remain in the current walk
        logic rvalid;    // read data from the previous cycle is present
        logic hit;       // search has found its value
    } ils_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ils_if.sv =====
// ----------------------------------------------------------------------------
// ils_if: request and response channels of the indexed list store
// Valid and ready handshake; a word moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ils_req_if
    import ils_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;

    modport source (output valid, output operation, output position,
                    output item_value, input ready);
    modport sink   (input valid, input operation, input position,
                    input item_value, output ready);
endinterface

interface ils_rsp_if
    import ils_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] read_value;
    logic [FPOS_W-1:0]       found_position;
    logic [CNT_W-1:0]        entry_count;

    modport source (output valid, output status, output read_value,
                    output found_position, output entry_count, input ready);
    modport sink   (input valid, input status, input read_value,
                    input found_position, input entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ils_ctrl.sv =====
// ----------------------------------------------------------------------------
// ils_ctrl: sequencing controller of the indexed list store
// Steps each request through load, walk over entries and finish, and owns
// the valid flag of the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ils_ctrl
    import ils_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  ils_stat_t stat,
    output ils_cmd_t  cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // The response register may be reloaded once its word has gone or goes now.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.need_walk ? CS_WALK : CS_FINISH;
                end
            end
            CS_WALK:
            begin
                if (stat.hit || (!stat.more && !stat.rvalid))
                begin
                    state_next = CS_FINISH;
                end
            end
            CS_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = (out_valid_reg && out_ready) ? 1'b0 : out_valid_reg;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            CS_WALK:
            begin
                cmd.walk  = 1'b1;
                cmd.rd_en = stat.more && !stat.hit;
            end
            CS_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ils_dp.sv =====
// ----------------------------------------------------------------------------
// ils_dp: datapath of the indexed list store
// Entry memory, count, walk pointer and read pipeline, and the response
// payload register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ils_dp
    import ils_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [OP_W-1:0]         in_operation,
    input  wire logic [POS_W-1:0]        in_position,
    input  wire logic signed [VAL_W-1:0] in_item_value,
    input  ils_cmd_t                     cmd,
    output ils_stat_t                    stat,
    output logic [ST_W-1:0]              status,
    output logic signed [VAL_W-1:0]      read_value,
    output logic [FPOS_W-1:0]            found_position,
    output logic [CNT_W-1:0]             entry_count
);

    logic signed [VAL_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    rvalid_reg;

    op_t                     op_reg;
    logic [ADDR_W-1:0]       pos_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic                    idx_ok_reg;
    logic                    full_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [ADDR_W-1:0]       rptr_reg;
    logic [ADDR_W-1:0]       rlast_reg;
    logic signed [VAL_W-1:0] rdata_reg;
    logic signed [VAL_W-1:0] rd_reg;
    logic                    found_reg;
    logic [ADDR_W-1:0]       fpos_reg;

    status_t                 status_reg;
    status_t                 status_next;
    logic signed [VAL_W-1:0] read_value_reg;
    logic signed [VAL_W-1:0] read_value_next;
    logic [FPOS_W-1:0]       found_position_reg;
    logic [FPOS_W-1:0]       found_position_next;
    logic [CNT_W-1:0]        entry_count_reg;

    op_t                     in_op;
    logic                    idx_ok_in;
    logic                    full_in;
    logic [CNT_W-1:0]        span_in;
    logic [ADDR_W-1:0]       rptr_init;
    logic [CNT_W-1:0]        rem_init;

    logic                    at_pos;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;

    // Checks on the request word at the input, used when it is latched.
    assign in_op     = op_t'(in_operation);
    assign idx_ok_in = in_position < POS_W'(count_reg);
    assign full_in   = count_reg == CNT_W'(CAPACITY);
    assign span_in   = count_reg - CNT_W'(in_position);

    always_comb
    begin
        rptr_init = ADDR_W'(in_position);
        rem_init  = '0;
        case (in_op)
            OP_INSERT:
            begin
                rptr_init = ADDR_W'(count_reg - 1'b1);
                rem_init  = span_in;
            end
            OP_REMOVE:
            begin
                rem_init = span_in;
            end
            OP_GET:
            begin
                rem_init = CNT_W'(1);
            end
            OP_FIND:
            begin
                rptr_init = '0;
                rem_init  = count_reg;
            end
            default:
            begin
                rem_init = '0;
            end
        endcase
    end

    assign stat.need_walk = ((in_op == OP_INSERT) && idx_ok_in && !full_in) ||
                            ((in_op == OP_REMOVE) && idx_ok_in) ||
                            ((in_op == OP_GET) && idx_ok_in) ||
                            (in_op == OP_FIND);
    assign stat.more      = rem_reg != '0;
    assign stat.rvalid    = rvalid_reg;
    assign stat.hit       = rvalid_reg && (op_reg == OP_FIND) && (rdata_reg == val_reg);

    assign at_pos = rlast_reg == pos_reg;

    // Single write port: entry moves during the walk, final write at finish.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = val_reg;
        if (cmd.walk && rvalid_reg)
        begin
            if (op_reg == OP_INSERT)
            begin
                mem_we    = 1'b1;
                mem_waddr = rlast_reg + 1'b1;
                mem_wdata = rdata_reg;
            end
            else if ((op_reg == OP_REMOVE) && !at_pos)
            begin
                mem_we    = 1'b1;
                mem_waddr = rlast_reg - 1'b1;
                mem_wdata = rdata_reg;
            end
        end
        else if (cmd.finish)
        begin
            case (op_reg)
                OP_APPEND:
                begin
                    mem_we    = !full_reg;
                    mem_waddr = ADDR_W'(count_reg);
                end
                OP_INSERT:
                begin
                    mem_we = idx_ok_reg && !full_reg;
                end
                OP_SET:
                begin
                    mem_we = idx_ok_reg;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    // Final result and count update.
    always_comb
    begin
        status_next         = ST_OK;
        read_value_next     = '0;
        found_position_next = '0;
        count_next          = count_reg;
        case (op_reg)
            OP_APPEND:
            begin
                if (full_reg)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (!idx_ok_reg)
                begin
                    status_next = ST_RANGE;
                end
                else if (full_reg)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_SET:
            begin
                if (!idx_ok_reg)
                begin
                    status_next = ST_RANGE;
                end
            end
            OP_REMOVE:
            begin
                if (!idx_ok_reg)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    read_value_next = rd_reg;
                    count_next      = count_reg - 1'b1;
                end
            end
            OP_GET:
            begin
                if (!idx_ok_reg)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    read_value_next = rd_reg;
                end
            end
            OP_FIND:
            begin
                if (found_reg)
                begin
                    found_position_next = FPOS_W'(fpos_reg);
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= cmd.rd_en;
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Entry memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            pos_reg    <= ADDR_W'(in_position);
            val_reg    <= in_item_value;
            idx_ok_reg <= idx_ok_in;
            full_reg   <= full_in;
            rptr_reg   <= rptr_init;
            rem_reg    <= rem_init;
            rd_reg     <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rlast_reg <= rptr_reg;
                rptr_reg  <= (op_reg == OP_INSERT) ? rptr_reg - 1'b1 : rptr_reg + 1'b1;
                rem_reg   <= rem_reg - 1'b1;
            end
            if (cmd.walk && rvalid_reg)
            begin
                if (((op_reg == OP_GET) || (op_reg == OP_REMOVE)) && at_pos)
                begin
                    rd_reg <= rdata_reg;
                end
                if (stat.hit)
                begin
                    found_reg <= 1'b1;
                    fpos_reg  <= rlast_reg;
                end
            end
        end
        if (cmd.finish)
        begin
            status_reg         <= status_next;
            read_value_reg     <= read_value_next;
            found_position_reg <= found_position_next;
            entry_count_reg    <= count_next;
        end
    end

    assign status         = status_reg;
    assign read_value     = read_value_reg;
    assign found_position = found_position_reg;
    assign entry_count    = entry_count_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_list_store.sv =====
// Append, set, clear, the unused code and rejected requests go straight to
// the finish step; get, insert, remove and find first walk over entries.
// Requests are handled one at a time: the next is taken only after the
// response register has loaded for the last one.
// Reset: asynchronous, active low; clears the count and the handshake state.
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of signed 32-bit values
// An ordered list held in a fixed store of CAPACITY entries, with append,
// insert, set, remove, get, find and clear on request words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// The block is split into a controller state machine and a datapath. The
// controller accepts a request word only when it is idle, then either goes
// straight to the finish step or walks the entry memory one entry per cycle.
//
// The walk uses a registered read. Every cycle the datapath may issue a
// read at the walk pointer and, in the same cycle, act on the data of
// the read issued in the previous cycle. Insert walks downwards from the last
// entry, writing each entry one place higher; remove walks upwards from the
// removed index, keeping the first value read as the returned word and
// writing each later entry one place lower. Find walks upwards from index
// zero and stops at the first match. Reads and writes in the same cycle never
// touch the same address, so no bypass is needed.
//
// The finish step performs the final write (append, set, or the new value of
// an insert), updates the count and loads the response register. It waits
// only while the previous response is still held and not yet taken, so a new
// request can be accepted while an earlier response waits on the output.
//
// Entries are never cleared; only indices below the count are read, and those
// have always been written beforehand.

module indexed_list_store
    import ils_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ils_req_if.sink   req,
    ils_rsp_if.source rsp
);

    ils_cmd_t  cmd;
    ils_stat_t stat;

    ils_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ils_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_operation   (req.operation),
        .in_position    (req.position),
        .in_item_value  (req.item_value),
        .cmd            (cmd),
        .stat           (stat),
        .status         (rsp.status),
        .read_value     (rsp.read_value),
        .found_position (rsp.found_position),
        .entry_count    (rsp.entry_count)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ils_chk.sv =====
// ----------------------------------------------------------------------------
// ils_chk: port-level checks for the indexed list store
// Watches the request and response ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ils_chk
    import ils_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    req_valid,
    input wire logic                    req_ready,
    input wire logic                    rsp_valid,
    input wire logic                    rsp_ready,
    input wire logic [ST_W-1:0]         rsp_status,
    input wire logic signed [VAL_W-1:0] rsp_read_value,
    input wire logic [FPOS_W-1:0]       rsp_found_position,
    input wire logic [CNT_W-1:0]        rsp_entry_count
);

    // A response word stays offered until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response withdrawn before it was taken");

    // One request at a time: after a word is taken the port closes.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request port stayed open after a word was taken");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == CNT_W'(CAPACITY))
        else $error("full status while the store has room");

    a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |->
            (rsp_read_value == '0) && (rsp_found_position == '0))
        else $error("error response carries a non-zero payload");

endmodule

bind indexed_list_store ils_chk u_ils_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_read_value     (rsp.read_value),
    .rsp_found_position (rsp.found_position),
    .rsp_entry_count    (rsp.entry_count)
);

`default_nettype wire

// ===== bench/indexed_list_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_tb: self-checking bench for the indexed list store
// Drives request words through the valid/ready channel, keeps a shadow copy
// of the list to predict each response word, and compares every response
// field by field. Covers empty and full lists, bad indices, searches that
// miss, the unused operation code, and long output back-pressure.
// ----------------------------------------------------------------------------

module indexed_list_store_tb;

    import ils_pkg::*;

    // Operation code 7 has no meaning; the block must answer it with an ok
    // status and leave the list alone.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // A request's walk is bounded by the capacity, and the long back-pressure
    // stretch is shorter than the quiet limit, so reaching it can only mean a hang.
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HOLD_CYCLES   = 400;

    logic clk;
    logic rst_n;

    ils_req_if req_ch ();
    ils_rsp_if rsp_ch ();

    indexed_list_store i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // One expected response word.
    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] read_value;
        logic [FPOS_W-1:0]       found_position;
        logic [CNT_W-1:0]        entry_count;
    } list_reply_t;

    // Shadow copy of the list, updated as each request word is accepted.
    logic signed [VAL_W-1:0] shadow_list [CAPACITY];
    int                      shadow_count = 0;

    // Responses predicted but not yet seen, oldest first.
    list_reply_t pending_replies [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_request    = 0;
    int mismatch_count  = 0;
    int random_serial   = 0;

    // ------------------------------------------------------------------------
    // Clock: 4 ns period.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Shadow list: applies one operation and returns the response word it
    // should produce. Index checks come before the full check, so an insert
    // at a bad index into a full list reports the index, not the fullness.
    // A clear only resets the length; old values stay put but are never
    // looked at again, since searches stop at the length.
    // ------------------------------------------------------------------------
    function automatic list_reply_t apply_to_shadow_list(input logic [OP_W-1:0] op,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic signed [VAL_W-1:0] value);
        list_reply_t reply;
        int          i;
        bit          index_ok;
        reply.status         = ST_OK;
        reply.read_value     = '0;
        reply.found_position = '0;
        index_ok             = (int'(pos) < shadow_count);
        case (op)
            OP_APPEND:
            begin
                if (shadow_count >= CAPACITY)
                    reply.status = ST_FULL;
                else
                begin
                    shadow_list[shadow_count] = value;
                    shadow_count++;
                end
            end
            OP_INSERT:
            begin
                if (!index_ok)
                    reply.status = ST_RANGE;
                else if (shadow_count >= CAPACITY)
                    reply.status = ST_FULL;
                else
                begin
                    for (i = shadow_count; i > int'(pos); i--)
                        shadow_list[i] = shadow_list[i - 1];
                    shadow_list[pos] = value;
                    shadow_count++;
                end
            end
            OP_SET:
            begin
                if (!index_ok)
                    reply.status = ST_RANGE;
                else
                    shadow_list[pos] = value;
            end
            OP_REMOVE:
            begin
                if (!index_ok)
                    reply.status = ST_RANGE;
                else
                begin
                    reply.read_value = shadow_list[pos];
                    for (i = int'(pos); i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                end
            end
            OP_GET:
            begin
                if (!index_ok)
                    reply.status = ST_RANGE;
                else
                    reply.read_value = shadow_list[pos];
            end
            OP_FIND:
            begin
                reply.status = ST_ABSENT;
                for (i = 0; i < shadow_count; i++)
                begin
                    if (shadow_list[i] == value)
                    begin
                        reply.status         = ST_OK;
                        reply.found_position = FPOS_W'(i);
                        break;
                    end
                end
            end
            OP_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        reply.entry_count = CNT_W'(shadow_count);
        return reply;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers one request word, with random idle cycles in front of
    // it, and records the predicted response once the word is taken. Valid
    // is left high after acceptance; the next call either replaces the word
    // or lowers valid at the following falling edge, which always comes
    // before the block can sample it again.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.position   <= pos;
        req_ch.item_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_replies.push_back(apply_to_shadow_list(op, pos, value));
    endtask

    // Values are drawn so that searches hit often: besides fully random
    // words there are small numbers that repeat, the two signed extremes,
    // and values already held in the list.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return signed'(VAL_W'($urandom_range(0, 7)) - VAL_W'(4));
            2:       return (shadow_count > 0) ?
                            shadow_list[$urandom_range(0, shadow_count - 1)] : $urandom;
            default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Response checker: every response word taken is compared with the
    // oldest prediction. A word with nothing waiting is an error too.
    // ------------------------------------------------------------------------
    initial
    begin : response_check
        list_reply_t want;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_replies.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected response word: status %0d value %0d pos %0d count %0d",
                             $time, rsp_ch.status, rsp_ch.read_value,
                             rsp_ch.found_position, rsp_ch.entry_count);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (rsp_ch.status !== want.status ||
                        rsp_ch.read_value !== want.read_value ||
                        rsp_ch.found_position !== want.found_position ||
                        rsp_ch.entry_count !== want.entry_count)
                    begin
                        mismatch_count++;
                        $display("%0t: expected status %0d value %0d pos %0d count %0d, actual status %0d value %0d pos %0d count %0d",
                                 $time, want.status, want.read_value,
                                 want.found_position, want.entry_count,
                                 rsp_ch.status, rsp_ch.read_value,
                                 rsp_ch.found_position, rsp_ch.entry_count);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: ready changes at the falling edge. A hold request from the
    // test sequence keeps ready low for that many cycles, counted here, so
    // that the output stalls while the sender keeps offering words.
    // ------------------------------------------------------------------------
    initial
    begin : response_sink
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no word moves on either channel for too long.
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("indexed_list_store test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Directed cases, starting from the empty list after reset: get, remove,
    // insert, set, find and append on an empty list, the signed extremes,
    // inserts and removes at the ends and in the middle, an index equal to
    // the length, the largest position, a search that misses, the unused code,
    // and a clear followed by a search for a value that is still in the store
    // but no longer in the list.
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_request(OP_GET,    8'd0, 32'sd0);
        send_request(OP_REMOVE, 8'd0, 32'sd0);
        send_request(OP_INSERT, 8'd0, 32'sd1);
        send_request(OP_SET,    8'd0, 32'sd2);
        send_request(OP_FIND,   8'd0, 32'sd0);
        send_request(OP_APPEND, 8'd0, 32'sh7FFF_FFFF);
        send_request(OP_APPEND, 8'd0, 32'sh8000_0000);
        send_request(OP_APPEND, 8'd0, -32'sd1);
        send_request(OP_APPEND, 8'd0, 32'sd0);
        send_request(OP_INSERT, 8'd0, 32'sh5A5A_5A5A);
        send_request(OP_INSERT, 8'd3, 32'shA5A5_A5A5);
        send_request(OP_SET,    8'd5, 32'sd12345);
        send_request(OP_GET,    8'd5, 32'sd0);
        send_request(OP_GET,    8'd6, 32'sd0);
        send_request(OP_GET,    8'd255, 32'sd0);
        send_request(OP_FIND,   8'd0, -32'sd1);
        send_request(OP_FIND,   8'd0, 32'sh8000_0000);
        send_request(OP_FIND,   8'd0, 32'sd99);
        send_request(OP_REMOVE, 8'd0, 32'sd0);
        send_request(OP_REMOVE, POS_W'(shadow_count - 1), 32'sd0);
        send_request(OP_REMOVE, 8'd2, 32'sd0);
        send_request(OP_UNUSED, 8'hFF, 32'shFFFF_FFFF);
        send_request(OP_CLEAR,  8'd0, 32'sd0);
        send_request(OP_FIND,   8'd0, -32'sd1);
        send_request(OP_APPEND, 8'd0, 32'sd7);
        send_request(OP_GET,    8'd0, 32'sd0);
    endtask

    // ------------------------------------------------------------------------
    // Full list: fill every entry, then check that append and insert are
    // refused, that a bad index still wins over fullness, and that the
    // longest walks (search to the last entry, shifts across the whole list)
    // come out right.
    // ------------------------------------------------------------------------
    task automatic test_full_store();
        int k;
        send_request(OP_CLEAR, 8'd0, 32'sd0);
        for (k = 0; k < CAPACITY; k++)
            send_request(OP_APPEND, POS_W'($urandom), $urandom);
        send_request(OP_APPEND, 8'd0, 32'sd1);
        send_request(OP_INSERT, 8'd10, 32'sd1);
        send_request(OP_INSERT, POS_W'(CAPACITY), 32'sd1);
        send_request(OP_INSERT, 8'd255, 32'sd1);
        send_request(OP_SET,    POS_W'(CAPACITY - 1), 32'sh1357_9BDF);
        send_request(OP_GET,    POS_W'(CAPACITY - 1), 32'sd0);
        send_request(OP_FIND,   8'd0, 32'sh1357_9BDF);
        send_request(OP_FIND,   8'd0, 32'sh0BAD_F00D);
        send_request(OP_REMOVE, 8'd0, 32'sd0);
        send_request(OP_INSERT, 8'd0, 32'sh8000_0000);
        send_request(OP_GET,    8'd0, 32'sd0);
        send_request(OP_REMOVE, POS_W'(CAPACITY - 1), 32'sd0);
    endtask

    // ------------------------------------------------------------------------
    // Random mix: runs alternate between growing and shrinking the list so
    // that its length wanders over the whole range. Positions are mostly
    // valid indices, sometimes exactly the length, sometimes anything.
    // ------------------------------------------------------------------------
    task automatic test_random_mix(input int item_total);
        int                      n;
        int                      roll;
        bit                      growing;
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        for (n = 0; n < item_total; n++)
        begin
            growing = ((random_serial / 90) % 2) == 0;
            random_serial++;
            roll = $urandom_range(0, 99);
            if (growing)
            begin
                if      (roll < 30) op = OP_APPEND;
                else if (roll < 45) op = OP_INSERT;
                else if (roll < 55) op = OP_SET;
                else if (roll < 67) op = OP_REMOVE;
                else if (roll < 79) op = OP_GET;
                else if (roll < 98) op = OP_FIND;
                else                op = OP_UNUSED;
            end
            else
            begin
                if      (roll < 12) op = OP_APPEND;
                else if (roll < 20) op = OP_INSERT;
                else if (roll < 30) op = OP_SET;
                else if (roll < 62) op = OP_REMOVE;
                else if (roll < 74) op = OP_GET;
                else if (roll < 94) op = OP_FIND;
                else if (roll < 97) op = OP_UNUSED;
                else                op = OP_CLEAR;
            end
            if (shadow_count > 0 && $urandom_range(0, 9) < 8)
                pos = POS_W'($urandom_range(0, shadow_count - 1));
            else if ($urandom_range(0, 1) == 1)
                pos = POS_W'(shadow_count);
            else
                pos = POS_W'($urandom_range(0, 255));
            send_request(op, pos, pick_value());
        end
    endtask

    // ------------------------------------------------------------------------
    // Back-pressure: the receiver holds ready low for a long stretch while
    // the sender keeps offering words, so the held response blocks the
    // finish step and the block stops taking requests.
    // ------------------------------------------------------------------------
    task automatic test_back_pressure();
        hold_request = HOLD_CYCLES;
        test_random_mix(30);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin : run_tests
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = '0;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalling.
        send_idle_pct = 14;
        recv_idle_pct = 76;
        test_directed();
        test_full_store();
        test_random_mix(150);

        // The other way round.
        send_idle_pct = 76;
        recv_idle_pct = 14;
        test_random_mix(150);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(150);
        test_back_pressure();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("indexed_list_store test passed");
        else
            $display("indexed_list_store test failed");
        $finish;
    end

endmodule
